// ===== rtl/core/gofp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gofp_pkg
// Types, widths and helpers shared by the gradient optical flow pixel core.
// ----------------------------------------------------------------------------
package gofp_pkg;

    localparam int PIX_W   = 8;
    localparam int AD_W    = 8;   // |prev - cur|
    localparam int AG_W    = 9;   // |gradient|
    localparam int PROD_W  = AD_W + AG_W;
    localparam int SQ_W    = 20;  // gx^2 + gy^2 + lambda
    localparam int RAD_W   = SQ_W + 16;
    localparam int MAG_W   = RAD_W / 2;
    localparam int NUM_W   = PROD_W + 16;
    localparam int Q_W     = NUM_W - 8;
    localparam int SCALE_W = 16;
    localparam int S_W     = Q_W + SCALE_W - 8;
    localparam int ML_W    = 24;
    localparam int CH_W    = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_FLOW_SCALE  = 2'd0;
    localparam logic [1:0] REG_REGULARIZER = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] prev_center;
        logic [PIX_W-1:0] cur_center;
        logic [PIX_W-1:0] prev_right;
        logic [PIX_W-1:0] prev_left;
        logic [PIX_W-1:0] cur_right;
        logic [PIX_W-1:0] cur_left;
        logic [PIX_W-1:0] prev_below;
        logic [PIX_W-1:0] prev_above;
        logic [PIX_W-1:0] cur_below;
        logic [PIX_W-1:0] cur_above;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] flow_pos_x;
        logic [CH_W-1:0] flow_neg_x;
        logic [CH_W-1:0] flow_pos_y;
        logic [CH_W-1:0] flow_neg_y;
    } t_flow;

    // classified item handed from front to back
    typedef struct packed {
        logic [PROD_W-1:0] nx;
        logic [PROD_W-1:0] ny;
        logic [SQ_W-1:0]   sq;
        logic              x_neg;
        logic              y_neg;
    } t_item;

    typedef struct packed {
        logic [SCALE_W-1:0] flow_scale;
        logic [ML_W-1:0]    min_length;
    } t_back_cfg;

    // round to nearest and saturate
    function automatic logic [CH_W-1:0] to_channel(input logic [S_W-1:0] s);
        logic [S_W:0] sum;
        begin
            sum = {1'b0, s} + (S_W+1)'(128);
            if (sum[S_W:8] > (S_W-7)'(255)) begin
                to_channel = 8'hff;
            end else begin
                to_channel = sum[15:8];
            end
        end
    endfunction

endpackage

// ===== rtl/core/gofp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gofp_front
// Takes stencil words, forms differences, gradients and products.
// ----------------------------------------------------------------------------
module gofp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gofp_pkg::t_pixel           i_pixel,
    input  logic [15:0]                i_regularizer,
    output logic                       o_valid,
    input  logic                       i_ready,
    output gofp_pkg::t_item            o_item
);

    logic                        r_valid;
    gofp_pkg::t_item             r_item;
    gofp_pkg::t_item             n_item;
    logic signed [8:0]           d;
    logic signed [9:0]           gx;
    logic signed [9:0]           gy;
    logic [9:0]                  agx_w;
    logic [9:0]                  agy_w;
    logic [8:0]                  ad_w;
    logic [gofp_pkg::AD_W-1:0]   ad;
    logic [gofp_pkg::AG_W-1:0]   agx;
    logic [gofp_pkg::AG_W-1:0]   agy;

    always_comb begin
        d  = $signed({1'b0, i_pixel.prev_center}) - $signed({1'b0, i_pixel.cur_center});
        gx = ($signed({2'b0, i_pixel.prev_right}) - $signed({2'b0, i_pixel.prev_left}))
           + ($signed({2'b0, i_pixel.cur_right})  - $signed({2'b0, i_pixel.cur_left}));
        gy = ($signed({2'b0, i_pixel.prev_below}) - $signed({2'b0, i_pixel.prev_above}))
           + ($signed({2'b0, i_pixel.cur_below})  - $signed({2'b0, i_pixel.cur_above}));
        ad_w  = d[8]  ? 9'(-d)  : 9'(d);
        agx_w = gx[9] ? 10'(-gx) : 10'(gx);
        agy_w = gy[9] ? 10'(-gy) : 10'(gy);
        ad  = ad_w[7:0];
        agx = agx_w[8:0];
        agy = agy_w[8:0];
        n_item.nx    = {9'd0, ad} * {8'd0, agx};
        n_item.ny    = {9'd0, ad} * {8'd0, agy};
        n_item.sq    = ({11'd0, agx} * {11'd0, agx}) + ({11'd0, agy} * {11'd0, agy})
                     + {4'd0, i_regularizer};
        n_item.x_neg = d[8] != gx[9];
        n_item.y_neg = d[8] != gy[9];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_item <= n_item;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/gofp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gofp_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module gofp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gofp_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output gofp_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gofp_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== rtl/core/gofp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gofp_back
// Pipelined square root, two dividers, scaling, threshold and channel split.
// ----------------------------------------------------------------------------
module gofp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gofp_pkg::t_item       i_item,
    input  gofp_pkg::t_back_cfg   i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gofp_pkg::t_flow       o_flow
);

    localparam int MAG_W = gofp_pkg::MAG_W;
    localparam int RAD_W = gofp_pkg::RAD_W;
    localparam int Q_W   = gofp_pkg::Q_W;
    localparam int NUM_W = gofp_pkg::NUM_W;
    localparam int S_W   = gofp_pkg::S_W;
    localparam int ML_W  = gofp_pkg::ML_W;
    localparam int DSH_W = MAG_W + Q_W;
    localparam int CH_W_L = gofp_pkg::CH_W;

    typedef struct packed {
        logic                          v;
        logic [gofp_pkg::PROD_W-1:0]   nx;
        logic [gofp_pkg::PROD_W-1:0]   ny;
        logic                          xn;
        logic                          yn;
        logic [MAG_W-1:0]              r;
        logic [RAD_W-1:0]              rem;
    } t_sq_st;

    typedef struct packed {
        logic             v;
        logic             xn;
        logic             yn;
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] remx;
        logic [NUM_W-1:0] remy;
        logic [Q_W-1:0]   qx;
        logic [Q_W-1:0]   qy;
    } t_dv_st;

    typedef struct packed {
        logic           v;
        logic           xn;
        logic           yn;
        logic           zero;
        logic [S_W-1:0] sx;
        logic [S_W-1:0] sy;
    } t_sc_st;

    typedef struct packed {
        logic              v;
        logic              xn;
        logic              yn;
        logic              zero;
        logic              big;
        logic [S_W-1:0]    sx;
        logic [S_W-1:0]    sy;
        logic [2*ML_W-1:0] sx2;
        logic [2*ML_W-1:0] sy2;
        logic [2*ML_W-1:0] ml2;
    } t_sqr_st;

    logic             adv;
    t_sq_st           sq_pipe [0:MAG_W];
    t_dv_st           dv_pipe [0:Q_W];
    t_sc_st           r_sc;
    t_sqr_st          r_sqr;
    logic             r_ov;
    gofp_pkg::t_flow  r_flow;
    gofp_pkg::t_flow  n_flow;

    // whole pipeline moves together unless the output word is stuck
    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    always_comb begin
        sq_pipe[0].v   = i_valid;
        sq_pipe[0].nx  = i_item.nx;
        sq_pipe[0].ny  = i_item.ny;
        sq_pipe[0].xn  = i_item.x_neg;
        sq_pipe[0].yn  = i_item.y_neg;
        sq_pipe[0].r   = '0;
        sq_pipe[0].rem = {i_item.sq, 16'd0};
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < MAG_W; k++) begin : g_sqrt
        localparam int B = MAG_W - 1 - k;
        logic [RAD_W+1:0] inc;
        logic             take;
        t_sq_st           nxt;

        always_comb begin
            inc  = ({(RAD_W+2-MAG_W)'(0), sq_pipe[k].r} << (B + 1))
                 + ((RAD_W+2)'(1) << (2 * B));
            take = {2'b00, sq_pipe[k].rem} >= inc;
            nxt  = sq_pipe[k];
            if (take) begin
                nxt.rem = sq_pipe[k].rem - inc[RAD_W-1:0];
                nxt.r   = sq_pipe[k].r | (MAG_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                sq_pipe[k+1].v <= 1'b0;
            end else if (adv) begin
                sq_pipe[k+1] <= nxt;
            end
        end
    end

    always_comb begin
        dv_pipe[0].v    = sq_pipe[MAG_W].v;
        dv_pipe[0].xn   = sq_pipe[MAG_W].xn;
        dv_pipe[0].yn   = sq_pipe[MAG_W].yn;
        dv_pipe[0].mag  = sq_pipe[MAG_W].r;
        dv_pipe[0].remx = {sq_pipe[MAG_W].nx, 16'd0};
        dv_pipe[0].remy = {sq_pipe[MAG_W].ny, 16'd0};
        dv_pipe[0].qx   = '0;
        dv_pipe[0].qy   = '0;
    end

    // restoring division of both axes, one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int B = Q_W - 1 - j;
        logic [DSH_W-1:0] dsh;
        t_dv_st           nxt;

        always_comb begin
            dsh = {(DSH_W-MAG_W)'(0), dv_pipe[j].mag} << B;
            nxt = dv_pipe[j];
            if ({(DSH_W-NUM_W)'(0), dv_pipe[j].remx} >= dsh) begin
                nxt.remx = dv_pipe[j].remx - dsh[NUM_W-1:0];
                nxt.qx   = dv_pipe[j].qx | (Q_W'(1) << B);
            end
            if ({(DSH_W-NUM_W)'(0), dv_pipe[j].remy} >= dsh) begin
                nxt.remy = dv_pipe[j].remy - dsh[NUM_W-1:0];
                nxt.qy   = dv_pipe[j].qy | (Q_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_pipe[j+1].v <= 1'b0;
            end else if (adv) begin
                dv_pipe[j+1] <= nxt;
            end
        end
    end

    // gain
    logic [Q_W+gofp_pkg::SCALE_W-1:0] px;
    logic [Q_W+gofp_pkg::SCALE_W-1:0] py;
    assign px = {(gofp_pkg::SCALE_W)'(0), dv_pipe[Q_W].qx}
              * {(Q_W)'(0), i_cfg.flow_scale};
    assign py = {(gofp_pkg::SCALE_W)'(0), dv_pipe[Q_W].qy}
              * {(Q_W)'(0), i_cfg.flow_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc.v <= 1'b0;
        end else if (adv) begin
            r_sc.v    <= dv_pipe[Q_W].v;
            r_sc.xn   <= dv_pipe[Q_W].xn;
            r_sc.yn   <= dv_pipe[Q_W].yn;
            r_sc.zero <= dv_pipe[Q_W].mag == '0;
            r_sc.sx   <= px[Q_W+gofp_pkg::SCALE_W-1:8];
            r_sc.sy   <= py[Q_W+gofp_pkg::SCALE_W-1:8];
        end
    end

    // squared lengths; anything at or above 2^24 always passes the threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqr.v <= 1'b0;
        end else if (adv) begin
            r_sqr.v    <= r_sc.v;
            r_sqr.xn   <= r_sc.xn;
            r_sqr.yn   <= r_sc.yn;
            r_sqr.zero <= r_sc.zero;
            r_sqr.big  <= (r_sc.sx[S_W-1:ML_W] != '0) || (r_sc.sy[S_W-1:ML_W] != '0);
            r_sqr.sx   <= r_sc.sx;
            r_sqr.sy   <= r_sc.sy;
            r_sqr.sx2  <= {(ML_W)'(0), r_sc.sx[ML_W-1:0]} * {(ML_W)'(0), r_sc.sx[ML_W-1:0]};
            r_sqr.sy2  <= {(ML_W)'(0), r_sc.sy[ML_W-1:0]} * {(ML_W)'(0), r_sc.sy[ML_W-1:0]};
            r_sqr.ml2  <= {(ML_W)'(0), i_cfg.min_length} * {(ML_W)'(0), i_cfg.min_length};
        end
    end

    logic              below;
    logic [CH_W_L-1:0] cx;
    logic [CH_W_L-1:0] cy;

    always_comb begin
        below = !r_sqr.big
             && (({1'b0, r_sqr.sx2} + {1'b0, r_sqr.sy2}) < {1'b0, r_sqr.ml2});
        cx = gofp_pkg::to_channel(r_sqr.sx);
        cy = gofp_pkg::to_channel(r_sqr.sy);
        n_flow = '0;
        if (!r_sqr.zero && !below) begin
            if (r_sqr.xn) begin
                n_flow.flow_neg_x = cx;
            end else begin
                n_flow.flow_pos_x = cx;
            end
            if (r_sqr.yn) begin
                n_flow.flow_neg_y = cy;
            end else begin
                n_flow.flow_pos_y = cy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov   <= r_sqr.v;
            r_flow <= n_flow;
        end
    end

    assign o_valid = r_ov;
    assign o_flow  = r_flow;

endmodule

// ===== rtl/core/gradient_optical_flow_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_optical_flow_pixel
// Per-pixel gradient optical flow from a five-point stencil of two frames.
// ----------------------------------------------------------------------------
// usage
//   input channel: one stencil word (i_pixel) per i_valid/o_ready handshake,
//   ten 8-bit samples from the previous and current frame
//   output channel: one flow word (o_flow) per o_valid/i_ready handshake,
//   four saturated channels +x, -x, +y, -y
//   config: APB-style port, flow_scale at 0x0, regularizer at 0x4,
//   min_length at 0x8; write only while the core is idle
//   throughput: one word per cycle, sustained while the output is not stalled
//   pipeline: the front register and queue, the 18-stage square root, the
//   25-stage dividers, then the gain, squared-length and output registers
//   reset: registers return to defaults, pipeline and queue empty
//   stall: a stalled output word freezes the back pipeline; the queue then
//   absorbs the front, and o_ready drops once queue and front are full
// ----------------------------------------------------------------------------
module gradient_optical_flow_pixel #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stencil words in
    input  logic                          i_valid,
    output logic                          o_ready,
    input  gofp_pkg::t_pixel              i_pixel,
    // flow words out
    output logic                          o_valid,
    input  logic                          i_ready,
    output gofp_pkg::t_flow               o_flow,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gofp_pkg::ADDR_W-1:0]   paddr,
    input  logic [gofp_pkg::DATA_W-1:0]   pwdata,
    output logic [gofp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [15:0]          r_flow_scale;
    logic [15:0]          r_regularizer;
    logic [23:0]          r_min_length;
    logic                 wr_en;

    logic                 fr_valid;
    logic                 fr_ready;
    gofp_pkg::t_item      fr_item;
    logic                 q_valid;
    logic                 q_ready;
    gofp_pkg::t_item      q_item;
    gofp_pkg::t_back_cfg  back_cfg;

    // register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_scale  <= 16'd2560;
            r_regularizer <= 16'd163;
            r_min_length  <= 24'd65280;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                gofp_pkg::REG_FLOW_SCALE:  r_flow_scale  <= pwdata[15:0];
                gofp_pkg::REG_REGULARIZER: r_regularizer <= pwdata[15:0];
                gofp_pkg::REG_MIN_LENGTH:  r_min_length  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gofp_pkg::REG_FLOW_SCALE:  prdata = {16'd0, r_flow_scale};
            gofp_pkg::REG_REGULARIZER: prdata = {16'd0, r_regularizer};
            gofp_pkg::REG_MIN_LENGTH:  prdata = {8'd0, r_min_length};
            default:                   prdata = '0;
        endcase
    end

    // front: differences, gradients, products
    gofp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .i_regularizer (r_regularizer),
        .o_valid       (fr_valid),
        .i_ready       (fr_ready),
        .o_item        (fr_item)
    );

    // decoupling queue
    gofp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    assign back_cfg.flow_scale = r_flow_scale;
    assign back_cfg.min_length = r_min_length;

    // back: magnitude, division, gain, threshold, channel split
    gofp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .i_cfg   (back_cfg),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_flow  (o_flow)
    );

    a_one_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flow.flow_pos_x == '0 || o_flow.flow_neg_x == '0))
        else $error("both x channels active");
    a_one_sign_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flow.flow_pos_y == '0 || o_flow.flow_neg_y == '0))
        else $error("both y channels active");
    a_scale_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && paddr[3:2] == gofp_pkg::REG_FLOW_SCALE)
        |=> (r_flow_scale == $past(pwdata[15:0])))
        else $error("flow_scale write lost");

endmodule

// ===== dv/tb_gradient_optical_flow_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_optical_flow_pixel
// Self-checking bench for the per-pixel gradient optical flow core: stencil
// words go in with random bursts and gaps, flow words are checked in order
// against a fixed-point prediction, under several register settings.
// ----------------------------------------------------------------------------
module tb_gradient_optical_flow_pixel;

    localparam int LATENCY     = 47;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PIX_BITS    = $bits(gofp_pkg::t_pixel);

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    gofp_pkg::t_pixel              i_pixel;
    logic                          o_valid;
    logic                          i_ready;
    gofp_pkg::t_flow               o_flow;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gofp_pkg::ADDR_W-1:0]   paddr;
    logic [gofp_pkg::DATA_W-1:0]   pwdata;
    logic [gofp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    gradient_optical_flow_pixel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_flow  (o_flow),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic [15:0] gain_q8;
    logic [15:0] lambda;
    logic [23:0] thresh_q8;

    gofp_pkg::t_flow  flow_queue[$];
    int     errors;
    longint cycles;
    int     hold_cycles;   // long receiver hold-off request

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // cycle count and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // integer square root, bit by bit
    function automatic longint unsigned root_of(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // expected flow word for one stencil
    function automatic gofp_pkg::t_flow flow_of(input gofp_pkg::t_pixel p);
        longint d, gx, gy;
        longint unsigned ad, agx, agy, mag, vx, vy, sx, sy, cx, cy;
        gofp_pkg::t_flow f;
        f = '0;
        d  = longint'(p.prev_center) - longint'(p.cur_center);
        gx = longint'(p.prev_right) - longint'(p.prev_left)
           + longint'(p.cur_right) - longint'(p.cur_left);
        gy = longint'(p.prev_below) - longint'(p.prev_above)
           + longint'(p.cur_below) - longint'(p.cur_above);
        ad  = d < 0 ? -d : d;
        agx = gx < 0 ? -gx : gx;
        agy = gy < 0 ? -gy : gy;
        mag = root_of((agx * agx + agy * agy + lambda) << 16);
        if (mag == 0) return f;
        vx = ((ad * agx) << 16) / mag;
        vy = ((ad * agy) << 16) / mag;
        sx = (vx * gain_q8) >> 8;
        sy = (vy * gain_q8) >> 8;
        if (sx * sx + sy * sy < longint'(thresh_q8) * thresh_q8) return f;
        cx = (sx + 128) >> 8;
        cy = (sy + 128) >> 8;
        if (cx > 255) cx = 255;
        if (cy > 255) cy = 255;
        if ((d < 0) != (gx < 0)) f.flow_neg_x = cx[7:0];
        else f.flow_pos_x = cx[7:0];
        if ((d < 0) != (gy < 0)) f.flow_neg_y = cy[7:0];
        else f.flow_pos_y = cy[7:0];
        return f;
    endfunction

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            // stretches of full readiness alternate with random stalls
            i_ready <= ((cycles / 200) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // checker: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        gofp_pkg::t_flow exp_f;
        if (i_rst_n && o_valid && i_ready) begin
            if (flow_queue.size() == 0) begin
                $display("%0t unexpected word: actual %h", $time, o_flow);
                errors++;
            end else begin
                exp_f = flow_queue.pop_front();
                if (o_flow.flow_pos_x !== exp_f.flow_pos_x) begin
                    $display("%0t flow_pos_x expected %0d actual %0d",
                             $time, exp_f.flow_pos_x, o_flow.flow_pos_x);
                    errors++;
                end
                if (o_flow.flow_neg_x !== exp_f.flow_neg_x) begin
                    $display("%0t flow_neg_x expected %0d actual %0d",
                             $time, exp_f.flow_neg_x, o_flow.flow_neg_x);
                    errors++;
                end
                if (o_flow.flow_pos_y !== exp_f.flow_pos_y) begin
                    $display("%0t flow_pos_y expected %0d actual %0d",
                             $time, exp_f.flow_pos_y, o_flow.flow_pos_y);
                    errors++;
                end
                if (o_flow.flow_neg_y !== exp_f.flow_neg_y) begin
                    $display("%0t flow_neg_y expected %0d actual %0d",
                             $time, exp_f.flow_neg_y, o_flow.flow_neg_y);
                    errors++;
                end
            end
        end
    end

    // offer one stencil word, hold it until accepted; gap after if asked
    task automatic send_pixel(input gofp_pkg::t_pixel p, input int gap);
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (!o_ready);
        flow_queue.push_back(flow_of(p));
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_pixel <= gofp_pkg::t_pixel'(PIX_BITS'({$urandom, $urandom, $urandom}));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random bursts with random gaps between them
    int burst_left;
    task automatic send_bursty(input gofp_pkg::t_pixel p);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
        end
        send_pixel(p, gap);
    endtask

    // wait for all words back, then let the pipe drain fully
    task automatic drain();
        i_valid <= 1'b0;
        while (flow_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            gofp_pkg::REG_FLOW_SCALE:  gain_q8   = value[15:0];
            gofp_pkg::REG_REGULARIZER: lambda    = value[15:0];
            gofp_pkg::REG_MIN_LENGTH:  thresh_q8 = value[23:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] g, input logic [15:0] l,
                            input logic [23:0] t);
        reg_write(gofp_pkg::REG_FLOW_SCALE, {16'h0, g});
        reg_write(gofp_pkg::REG_REGULARIZER, {16'h0, l});
        reg_write(gofp_pkg::REG_MIN_LENGTH, {8'h0, t});
    endtask

    function automatic gofp_pkg::t_pixel rand_pixel();
        gofp_pkg::t_pixel p;
        p = gofp_pkg::t_pixel'(PIX_BITS'({$urandom, $urandom, $urandom}));
        // now and then pin samples to the rails or make two samples equal
        if ($urandom_range(0, 7) == 0) p.prev_center = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 7) == 0) p.cur_center  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 5) == 0) p.cur_center  = p.prev_center;
        if ($urandom_range(0, 7) == 0) begin
            p.prev_right = p.prev_left;
            p.cur_right  = p.cur_left;
        end
        return p;
    endfunction

    // extremes, zero gradient, zero difference, all sign combinations
    task automatic test_directed();
        gofp_pkg::t_pixel p;
        send_pixel('0, 0);
        send_pixel('1, 0);
        for (int k = 0; k < 16; k++) begin
            p = '0;
            p.prev_center = k[0] ? 8'hff : 8'h00;
            p.cur_center  = k[0] ? 8'h00 : 8'hff;
            p.prev_right  = k[1] ? 8'hff : 8'h00;
            p.cur_right   = k[1] ? 8'hff : 8'h00;
            p.prev_left   = k[1] ? 8'h00 : 8'hff;
            p.cur_left    = k[1] ? 8'h00 : 8'hff;
            p.prev_below  = k[2] ? 8'hff : 8'h00;
            p.cur_below   = k[2] ? 8'h20 : 8'h00;
            p.prev_above  = k[2] ? 8'h00 : 8'hff;
            p.cur_above   = k[2] ? 8'h00 : 8'h20;
            if (k[3]) p.cur_center = p.prev_center;  // no temporal change
            send_pixel(p, k % 3);
        end
        p = '0;
        p.prev_center = 8'd10;
        p.cur_center  = 8'd9;
        p.prev_right  = 8'd1;
        send_pixel(p, 0);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) send_bursty(rand_pixel());
        drain();
    endtask

    // hold the receiver off long enough that the input stalls
    task automatic test_backpressure();
        hold_cycles = 150;
        for (int k = 0; k < 80; k++) send_pixel(rand_pixel(), 0);
        drain();
    endtask

    initial begin
        errors      = 0;
        cycles      = 0;
        hold_cycles = 0;
        burst_left  = 0;
        i_valid     = 1'b0;
        i_pixel     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gain_q8     = 16'd2560;
        lambda      = 16'd163;
        thresh_q8   = 24'd65280;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults
        test_directed();
        test_random(100);
        // no threshold, zero lambda, unit gain
        set_regs(16'd256, 16'd0, 24'd0);
        test_directed();
        test_random(120);
        // zero lambda and zero gain
        set_regs(16'd0, 16'd0, 24'd0);
        test_random(40);
        // largest gain and lambda, small threshold
        set_regs(16'hffff, 16'hffff, 24'd300);
        test_random(120);
        test_backpressure();
        // largest threshold zeroes everything
        set_regs(16'hffff, 16'd1, 24'hffffff);
        test_random(40);
        // mid settings
        set_regs(16'd1000, 16'd50, 24'd1000);
        test_random(150);

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && flow_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
